// File: design/seven_segment_digit_scanner_macros.svh
// ----------------------------------------------------------------------------
// Seven-segment digit scanner assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_DIGIT_SCANNER_MACROS_SVH
`define SEVEN_SEGMENT_DIGIT_SCANNER_MACROS_SVH

`ifndef SYNTHESIS
`define SSDS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ssds assertion failed");
`else
`define SSDS_ASSERT(lbl, clk, rst_n, prop)
`endif

`ifndef SYNTHESIS
`define SSDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssds assertion failed");
`else
`define SSDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/ssds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssds_pkg
// Shared types, opcodes, constants and the segment table of the digit scanner.
// ----------------------------------------------------------------------------
package ssds_pkg;

  localparam int NUM_DIGITS  = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_HEX        = 2'd0;
  localparam logic [1:0] OP_TIME_BLANK = 2'd1;
  localparam logic [1:0] OP_TIME_FULL  = 2'd2;
  localparam logic [1:0] OP_TIME_SKIP  = 2'd3;

  // hex leading-digit thresholds
  localparam logic [15:0] HEX_LIM1 = 16'd16;
  localparam logic [15:0] HEX_LIM2 = 16'd256;
  localparam logic [15:0] HEX_LIM3 = 16'd4096;
  // time leading-digit thresholds
  localparam logic [15:0] TIME_LIM1 = 16'd10;
  localparam logic [15:0] TIME_LIM2 = 16'd60;
  localparam logic [15:0] TIME_LIM3 = 16'd600;

  // reciprocals: v/60 = (v*RECIP_60)>>22, m/10 = (m*RECIP_10)>>16,
  // s/10 = (s*RECIP_S10)>>7 for s<60, q mod 6 via (q*RECIP_6)>>10 for q<110
  localparam logic [16:0] RECIP_60  = 17'd69906;
  localparam logic [12:0] RECIP_10  = 13'd6554;
  localparam logic [3:0]  RECIP_S10 = 4'd13;
  localparam logic [7:0]  RECIP_6   = 8'd171;

  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  opcode;
    logic [2:0]  skip_select;
  } ssds_in_t;

  typedef struct packed {
    logic [3:0] digit_enable_n;
    logic [7:0] segments;
    logic       last;
  } ssds_out_t;

  // one classified item: a pattern per position and which positions to scan
  typedef struct packed {
    logic [NUM_DIGITS-1:0][7:0] pat;
    logic [NUM_DIGITS-1:0]      mask;
  } ssds_job_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic      valid;
    ssds_job_t job;
  } ssds_head_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'h0: s = 8'h3F;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5B;
      4'h3: s = 8'h4F;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6D;
      4'h6: s = 8'h7D;
      4'h7: s = 8'h27;
      4'h8: s = 8'h7F;
      4'h9: s = 8'h67;
      4'hA: s = 8'h77;
      4'hB: s = 8'h7C;
      4'hC: s = 8'h39;
      4'hD: s = 8'h5E;
      4'hE: s = 8'h79;
      4'hF: s = 8'h71;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// File: design/ssds_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssds_front
// Four-stage digit split and classification; pushes one job per item.
// ----------------------------------------------------------------------------
module ssds_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ssds_pkg::ssds_in_t  in_data,
  output logic                busy,
  input  logic                q_full,
  output logic                q_push,
  output ssds_pkg::ssds_job_t q_job
);
  import ssds_pkg::*;

  logic adv;

  // stage A: v/60
  logic       a_vld_r;
  ssds_in_t   a_item_r;
  logic [10:0] a_q60_r;
  logic [32:0] a_prod;

  // stage B: minutes and seconds
  logic       b_vld_r;
  ssds_in_t   b_item_r;
  logic [10:0] b_min_r;
  logic [5:0]  b_sec_r;
  logic [16:0] b_q60x60;
  logic [16:0] b_sec_full;

  // stage C: split seconds, minutes/10
  logic       c_vld_r;
  ssds_in_t   c_item_r;
  logic [2:0] c_sec_t_r;
  logic [3:0] c_sec_u_r;
  logic [3:0] c_min_u_r;
  logic [6:0] c_min_q_r;
  logic [9:0]  c_sprod;
  logic [2:0]  c_sec_t;
  logic [5:0]  c_sec_u;
  logic [23:0] c_mprod;
  logic [6:0]  c_min_q;
  logic [10:0] c_min_u;

  // stage D: mod 6, table lookup, digit mask
  logic       d_vld_r;
  ssds_job_t  d_job_r;
  ssds_job_t  d_job_nxt;
  logic [14:0] d_prod6;
  logic [6:0]  d_min_t;
  logic [NUM_DIGITS-1:0][3:0] d_dig;
  logic [NUM_DIGITS-1:0]      d_mask;
  logic [15:0] v;
  logic        is_hex;

  assign adv  = !(d_vld_r && q_full);
  assign busy = !adv;

  assign a_prod = {17'd0, in_data.value} * {16'd0, RECIP_60};

  assign b_q60x60   = {6'd0, a_q60_r} * 17'd60;
  assign b_sec_full = {1'b0, a_item_r.value} - b_q60x60;

  assign c_sprod = {4'd0, b_sec_r} * {6'd0, RECIP_S10};
  assign c_sec_t = c_sprod[9:7];
  assign c_sec_u = b_sec_r - (6'(c_sec_t) * 6'd10);
  assign c_mprod = {13'd0, b_min_r} * {11'd0, RECIP_10};
  assign c_min_q = c_mprod[22:16];
  assign c_min_u = b_min_r - (11'(c_min_q) * 11'd10);

  assign d_prod6 = {8'd0, c_min_q_r} * {7'd0, RECIP_6};
  assign d_min_t = c_min_q_r - (7'(d_prod6[14:10]) * 7'd6);
  assign v       = c_item_r.value;
  assign is_hex  = (c_item_r.opcode == OP_HEX);

  always_comb begin
    d_dig[0] = is_hex ? v[3:0]   : c_sec_u_r;
    d_dig[1] = is_hex ? v[7:4]   : {1'b0, c_sec_t_r};
    d_dig[2] = is_hex ? v[11:8]  : c_min_u_r;
    d_dig[3] = is_hex ? v[15:12] : d_min_t[3:0];
    case (c_item_r.opcode)
      OP_HEX: begin
        d_mask = {v >= HEX_LIM3, v >= HEX_LIM2, v >= HEX_LIM1, 1'b1};
      end
      OP_TIME_BLANK: begin
        d_mask = {v >= TIME_LIM3, v >= TIME_LIM2, v >= TIME_LIM1, 1'b1};
      end
      OP_TIME_SKIP: begin
        case (c_item_r.skip_select)
          3'd1: d_mask = 4'b1110;
          3'd2: d_mask = 4'b1101;
          3'd3: d_mask = 4'b1011;
          3'd4: d_mask = 4'b0111;
          default: d_mask = 4'b1111;
        endcase
      end
      default: begin
        d_mask = 4'b1111;
      end
    endcase
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d_job_nxt.pat[i] = seg_of(d_dig[i]);
    end
    d_job_nxt.mask = d_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= start;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item_r  <= in_data;
      a_q60_r   <= a_prod[32:22];
      b_item_r  <= a_item_r;
      b_min_r   <= a_q60_r;
      b_sec_r   <= b_sec_full[5:0];
      c_item_r  <= b_item_r;
      c_sec_t_r <= c_sec_t;
      c_sec_u_r <= c_sec_u[3:0];
      c_min_u_r <= c_min_u[3:0];
      c_min_q_r <= c_min_q;
      d_job_r   <= d_job_nxt;
    end
  end

  assign q_push = d_vld_r && !q_full;
  assign q_job  = d_job_r;

endmodule

// File: design/ssds_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssds_queue
// Two-entry job queue between classification and scan-out.
// ----------------------------------------------------------------------------
`include "seven_segment_digit_scanner_macros.svh"

module ssds_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ssds_pkg::ssds_job_t  push_job,
  output logic                 full,
  input  logic                 pop,
  output ssds_pkg::ssds_head_t head
);
  import ssds_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ssds_job_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               cnt_full;

  assign cnt_full   = (cnt_r == CNT_W'(QUEUE_DEPTH));
  // a pop in the same cycle frees the slot
  assign full       = cnt_full && !pop;
  assign head.valid = (cnt_r != '0);
  assign head.job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `SSDS_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(QUEUE_DEPTH))
  `SSDS_ASSERT(a_no_overflow, clk, rst_n, (push && cnt_full) |-> pop)
  `SSDS_ASSERT_NEXT(a_push_seen, clk, rst_n, push && !pop, cnt_r != '0)

endmodule

// File: design/ssds_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssds_back
// Scan-out: one digit result per cycle from the current job.
// ----------------------------------------------------------------------------
`include "seven_segment_digit_scanner_macros.svh"

module ssds_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ssds_pkg::ssds_head_t  head,
  output logic                  pop,
  output logic                  out_strobe,
  output ssds_pkg::ssds_out_t   out_data
);
  import ssds_pkg::*;

  logic [NUM_DIGITS-1:0]      cur_mask_r, cur_mask_nxt;
  logic [NUM_DIGITS-1:0][7:0] cur_pat_r, cur_pat_nxt;
  logic [NUM_DIGITS-1:0]      low;
  logic [NUM_DIGITS-1:0]      rem;
  logic                       out_strobe_r;
  ssds_out_t                  out_r, out_nxt;

  always_comb begin
    low = cur_mask_r & (~cur_mask_r + 1'b1);
    rem = cur_mask_r & ~low;
    out_nxt.segments = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      out_nxt.digit_enable_n[NUM_DIGITS-1-i] = ~low[i];
      if (low[i]) begin
        out_nxt.segments = cur_pat_r[i];
      end
    end
    out_nxt.last = (rem == '0);
    pop          = (rem == '0) && head.valid;
    cur_mask_nxt = pop ? head.job.mask : rem;
    cur_pat_nxt  = pop ? head.job.pat  : cur_pat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mask_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      cur_mask_r   <= cur_mask_nxt;
      out_strobe_r <= (cur_mask_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    cur_pat_r <= cur_pat_nxt;
    out_r     <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  `SSDS_ASSERT(a_one_digit, clk, rst_n, out_strobe_r |-> $countones(~out_r.digit_enable_n) == 1)
  `SSDS_ASSERT_NEXT(a_scan_emits, clk, rst_n, cur_mask_r != '0, out_strobe_r)

endmodule

// File: design/seven_segment_digit_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_digit_scanner
// Splits a value into four seven-segment digits and scans them out one by one.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data (value, opcode, skip_select) with start high; the
//   request is taken on a rising edge where busy is low. Requests may be
//   issued every cycle while busy stays low.
//   Output: each digit result (digit_enable_n, segments, last) appears on
//   out_data for exactly one cycle with out_strobe high. last marks the
//   final digit of a request. The receiver cannot stall the block.
//   A taken request passes three more front stages, the queue, the scan
//   register and the output register before its first digit strobes.
//   Each request holds the scan-out stage for as many digits as it scans
//   (1 to 4), the scan-out stage emitting one digit per cycle. Digits of
//   successive requests follow with no gap while the next job is queued.
//   busy rises when the front pipeline's last stage cannot push into the
//   full job queue; the front then holds all stages.
//   Reset (rst_n low, synchronous) empties the pipeline and queue; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module seven_segment_digit_scanner (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  ssds_pkg::ssds_in_t   in_data,
  output logic                 busy,
  output logic                 out_strobe,
  output ssds_pkg::ssds_out_t  out_data
);
  import ssds_pkg::*;

  // front -> queue
  logic       q_push;
  logic       q_full;
  ssds_job_t  q_job;
  // queue -> back
  ssds_head_t q_head;
  logic       q_pop;

  // classification: time digits via reciprocal multiplies, mask of digits
  ssds_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .busy    (busy),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_job)
  );

  // short decoupling queue; full accounts for a same-cycle pop
  ssds_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  // scan-out: lowest remaining digit each cycle, next job loads on the last
  ssds_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .pop        (q_pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
